// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the design folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, a, b)
`define ASSERT_NXT(lbl, a, b)
`endif
`endif

// File: design/fdr_pkg.sv
// ---------------------------------------------------------------------------
// fdr_pkg
// Constants and types for the Fresnel reflectance pipeline.
// ---------------------------------------------------------------------------
package fdr_pkg;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  // per-item values carried alongside the arithmetic units
  typedef struct packed {
    logic [15:0] c;
    logic [15:0] ei;
    logic [15:0] et;
    logic        forced;
  } fdr_side_t;

endpackage

// File: design/fdr_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// fdr_sqrt_pipe
// Pipelined integer square root of a 31-bit value, one result bit a stage.
// ---------------------------------------------------------------------------
module fdr_sqrt_pipe #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [30:0]     in_radicand,
  input  logic [SB_W-1:0] in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_root,
  output logic [SB_W-1:0] out_side
);

  localparam int N = 16;

  logic            v_r    [N];
  logic [30:0]     rem_r  [N];
  logic [31:0]     res_r  [N];
  logic [SB_W-1:0] side_r [N];
  logic            en     [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
    logic            vi;
    logic [30:0]     remi;
    logic [31:0]     resi;
    logic [SB_W-1:0] sidei;
    logic [31:0]     trial;
    logic [30:0]     rem_nxt;
    logic [31:0]     res_nxt;

    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign remi  = in_radicand;
      assign resi  = '0;
      assign sidei = in_side;
    end else begin : g_next
      assign vi    = v_r[k-1];
      assign remi  = rem_r[k-1];
      assign resi  = res_r[k-1];
      assign sidei = side_r[k-1];
    end

    if (k == N - 1) begin : g_last_rdy
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid_rdy
      assign en[k] = !v_r[k] || en[k+1];
    end

    // try subtracting the next square bit
    always_comb begin
      trial = resi + BIT;
      if ({1'b0, remi} >= trial) begin
        rem_nxt = remi - trial[30:0];
        res_nxt = (resi >> 1) + BIT;
      end else begin
        rem_nxt = remi;
        res_nxt = resi >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= sidei;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];
  assign out_root  = res_r[N-1][15:0];
  assign out_side  = side_r[N-1];

endmodule

// File: design/fdr_div_pipe.sv
// ---------------------------------------------------------------------------
// fdr_div_pipe
// Pipelined restoring divider, one quotient bit a stage.
// ---------------------------------------------------------------------------
module fdr_div_pipe #(
  parameter int N_W  = 32,
  parameter int D_W  = 16,
  parameter int Q_W  = 15,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [N_W-1:0]  in_num,
  input  logic [D_W-1:0]  in_den,
  input  logic [SB_W-1:0] in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [Q_W-1:0]  out_quot,
  output logic [SB_W-1:0] out_side
);

  localparam int W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic            v_r    [Q_W];
  logic [W-1:0]    rem_r  [Q_W];
  logic [D_W-1:0]  den_r  [Q_W];
  logic [Q_W-1:0]  q_r    [Q_W];
  logic [SB_W-1:0] side_r [Q_W];
  logic            en     [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int POS = Q_W - 1 - k;
    logic            vi;
    logic [W-1:0]    remi;
    logic [D_W-1:0]  deni;
    logic [Q_W-1:0]  qi;
    logic [SB_W-1:0] sidei;
    logic [W-1:0]    dsh;
    logic [W-1:0]    rem_nxt;
    logic [Q_W-1:0]  q_nxt;

    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign remi  = W'(in_num);
      assign deni  = in_den;
      assign qi    = '0;
      assign sidei = in_side;
    end else begin : g_next
      assign vi    = v_r[k-1];
      assign remi  = rem_r[k-1];
      assign deni  = den_r[k-1];
      assign qi    = q_r[k-1];
      assign sidei = side_r[k-1];
    end

    if (k == Q_W - 1) begin : g_last_rdy
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid_rdy
      assign en[k] = !v_r[k] || en[k+1];
    end

    // subtract the shifted divisor where it fits
    always_comb begin
      dsh   = W'(deni) << POS;
      q_nxt = qi;
      if (remi >= dsh) begin
        rem_nxt    = remi - dsh;
        q_nxt[POS] = 1'b1;
      end else begin
        rem_nxt = remi;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= deni;
        q_r[k]    <= q_nxt;
        side_r[k] <= sidei;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[Q_W-1];
  assign out_quot  = q_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

// File: design/fresnel_dielectric_reflectance.sv
// ---------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarised dielectric Fresnel reflectance, fully pipelined.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   cos_incident, eta_incident, eta_transmit
// out_     output     out_valid / out_ready reflectance, total_reflection
//
// One item per cycle while the output is not stalled; the path holds two
// 16-stage square roots, a 15-stage and a 17-stage divider, and seven arithmetic stages.
// Each stage holds only while its successor is full and stalled, so bubbles
// close up and items keep entering while a result waits at the output.
// Synchronous active-low reset clears the valid bits only.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module fresnel_dielectric_reflectance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_cos_incident,
  input  logic [15:0] in_eta_incident,
  input  logic [15:0] in_eta_transmit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_reflectance,
  output logic        out_total_reflection
);

  localparam int SB_W = $bits(fdr_pkg::fdr_side_t);

  // ---- stage 0: swap indices, form 1 - cos^2
  logic                s0_v_r;
  logic                s0_en;
  fdr_pkg::fdr_side_t  s0_side_r, s0_side_nxt;
  logic [30:0]         s0_rad_r, s0_rad_nxt;
  logic [15:0]         raw;
  logic [30:0]         csq;
  logic                sq1_in_ready;

  always_comb begin
    raw = in_cos_incident;
    s0_side_nxt.forced = 1'b0;
    if (raw == 16'd0 || raw[15]) begin
      s0_side_nxt.ei = in_eta_transmit;
      s0_side_nxt.et = in_eta_incident;
      s0_side_nxt.c  = 16'(17'h1_0000 - {1'b0, raw});
    end else begin
      s0_side_nxt.ei = in_eta_incident;
      s0_side_nxt.et = in_eta_transmit;
      s0_side_nxt.c  = raw;
    end
    s0_side_nxt.forced = (s0_side_nxt.et == 16'd0);
    // a cosine of exactly one squares to 2^30, so keep the full 31 bits
    csq        = 31'(32'(s0_side_nxt.c) * 32'(s0_side_nxt.c));
    s0_rad_nxt = fdr_pkg::ONE_Q30 - csq;
  end

  assign s0_en    = !s0_v_r || sq1_in_ready;
  assign in_ready = s0_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_side_r <= s0_side_nxt;
      s0_rad_r  <= s0_rad_nxt;
    end
  end

  // ---- incident sine
  logic               sq1_v;
  logic [15:0]        sq1_si;
  fdr_pkg::fdr_side_t sq1_side;
  logic               s1_en;

  fdr_sqrt_pipe #(.SB_W(SB_W)) u_sqrt_si (
    .clk, .rst_n,
    .in_valid(s0_v_r), .in_ready(sq1_in_ready),
    .in_radicand(s0_rad_r), .in_side(s0_side_r),
    .out_valid(sq1_v), .out_ready(s1_en),
    .out_root(sq1_si), .out_side(sq1_side)
  );

  // ---- stage 1: ei * si, total internal reflection test
  logic               s1_v_r;
  fdr_pkg::fdr_side_t s1_side_r, s1_side_nxt;
  logic [31:0]        s1_num_r, s1_num_nxt;
  logic               dv1_in_ready;

  always_comb begin
    s1_num_nxt  = 32'(sq1_side.ei) * 32'(sq1_si);
    s1_side_nxt = sq1_side;
    if (s1_num_nxt >= {1'b0, sq1_side.et, 15'd0}) begin
      s1_side_nxt.forced = 1'b1;
    end
  end

  assign s1_en = !s1_v_r || dv1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= sq1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_side_r <= s1_side_nxt;
      s1_num_r  <= s1_num_nxt;
    end
  end

  // ---- transmitted sine
  logic               dv1_v;
  logic [14:0]        dv1_st;
  fdr_pkg::fdr_side_t dv1_side;
  logic               s2_en;

  fdr_div_pipe #(.N_W(32), .D_W(16), .Q_W(15), .SB_W(SB_W)) u_div_st (
    .clk, .rst_n,
    .in_valid(s1_v_r), .in_ready(dv1_in_ready),
    .in_num(s1_num_r), .in_den(s1_side_r.et), .in_side(s1_side_r),
    .out_valid(dv1_v), .out_ready(s2_en),
    .out_quot(dv1_st), .out_side(dv1_side)
  );

  // ---- stage 2: 1 - st^2
  logic               s2_v_r;
  fdr_pkg::fdr_side_t s2_side_r;
  logic [30:0]        s2_rad_r;
  logic [29:0]        stsq;
  logic               sq2_in_ready;

  assign stsq  = 30'(30'(dv1_st) * 30'(dv1_st));
  assign s2_en = !s2_v_r || sq2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= dv1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_side_r <= dv1_side;
      s2_rad_r  <= fdr_pkg::ONE_Q30 - {1'b0, stsq};
    end
  end

  // ---- transmitted cosine
  logic               sq2_v;
  logic [15:0]        sq2_ct;
  fdr_pkg::fdr_side_t sq2_side;
  logic               s3_en;

  fdr_sqrt_pipe #(.SB_W(SB_W)) u_sqrt_ct (
    .clk, .rst_n,
    .in_valid(s2_v_r), .in_ready(sq2_in_ready),
    .in_radicand(s2_rad_r), .in_side(s2_side_r),
    .out_valid(sq2_v), .out_ready(s3_en),
    .out_root(sq2_ct), .out_side(sq2_side)
  );

  // ---- stage 3: the four products
  logic        s3_v_r;
  logic        s3_forced_r;
  logic [31:0] s3_a_r, s3_b_r, s3_d_r, s3_e_r;
  logic        s4_en;

  assign s3_en = !s3_v_r || s4_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= sq2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_forced_r <= sq2_side.forced;
      s3_a_r <= 32'(sq2_side.et) * 32'(sq2_side.c);
      s3_b_r <= 32'(sq2_side.ei) * 32'(sq2_ct);
      s3_d_r <= 32'(sq2_side.ei) * 32'(sq2_side.c);
      s3_e_r <= 32'(sq2_side.et) * 32'(sq2_ct);
    end
  end

  // ---- stage 4: sums, differences, zero denominator
  logic        s4_v_r;
  logic        s4_forced_r;
  logic [47:0] s4_np_r, s4_ns_r;
  logic [32:0] s4_dp_r, s4_ds_r;
  logic [32:0] sum_p, sum_s;
  logic [31:0] dif_p, dif_s;
  logic        dvp_in_ready, dvs_in_ready;

  always_comb begin
    sum_p = {1'b0, s3_a_r} + {1'b0, s3_b_r};
    sum_s = {1'b0, s3_d_r} + {1'b0, s3_e_r};
    dif_p = (s3_a_r >= s3_b_r) ? s3_a_r - s3_b_r : s3_b_r - s3_a_r;
    dif_s = (s3_d_r >= s3_e_r) ? s3_d_r - s3_e_r : s3_e_r - s3_d_r;
  end

  assign s4_en = !s4_v_r || dvp_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_forced_r <= s3_forced_r || sum_p == 33'd0 || sum_s == 33'd0;
      s4_np_r     <= {dif_p, 16'd0};
      s4_ns_r     <= {dif_s, 16'd0};
      s4_dp_r     <= sum_p;
      s4_ds_r     <= sum_s;
    end
  end

  // ---- amplitude ratios; the two dividers move in lockstep
  logic        dvp_v, dvs_v;
  logic [16:0] dvp_q, dvs_q;
  logic        dvp_forced, dvs_forced;
  logic        s5_en;

  fdr_div_pipe #(.N_W(48), .D_W(33), .Q_W(17), .SB_W(1)) u_div_rp (
    .clk, .rst_n,
    .in_valid(s4_v_r), .in_ready(dvp_in_ready),
    .in_num(s4_np_r), .in_den(s4_dp_r), .in_side(s4_forced_r),
    .out_valid(dvp_v), .out_ready(s5_en),
    .out_quot(dvp_q), .out_side(dvp_forced)
  );

  fdr_div_pipe #(.N_W(48), .D_W(33), .Q_W(17), .SB_W(1)) u_div_rs (
    .clk, .rst_n,
    .in_valid(s4_v_r), .in_ready(dvs_in_ready),
    .in_num(s4_ns_r), .in_den(s4_ds_r), .in_side(s4_forced_r),
    .out_valid(dvs_v), .out_ready(s5_en),
    .out_quot(dvs_q), .out_side(dvs_forced)
  );

  // ---- stage 5: squares
  logic        s5_v_r;
  logic        s5_forced_r;
  logic [33:0] s5_pp_r, s5_ss_r;
  logic        s6_en;

  assign s5_en = !s5_v_r || s6_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_en) begin
      s5_v_r <= dvp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_forced_r <= dvp_forced;
      s5_pp_r     <= 34'(dvp_q) * 34'(dvp_q);
      s5_ss_r     <= 34'(dvs_q) * 34'(dvs_q);
    end
  end

  // ---- stage 6: mean with rounding, output register
  logic        s6_v_r;
  logic [16:0] s6_refl_r;
  logic        s6_tir_r;
  logic [34:0] mean_sum;

  assign mean_sum = {1'b0, s5_pp_r} + {1'b0, s5_ss_r} + 35'(fdr_pkg::ONE_Q16);
  assign s6_en    = !s6_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (s6_en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_en) begin
      s6_tir_r  <= s5_forced_r;
      s6_refl_r <= s5_forced_r ? fdr_pkg::ONE_Q16 : mean_sum[33:17];
    end
  end

  assign out_valid            = s6_v_r;
  assign out_reflectance      = s6_refl_r;
  assign out_total_reflection = s6_tir_r;

  // ---- checks
  `ASSERT_IMP(a_refl_range, out_valid, out_reflectance <= fdr_pkg::ONE_Q16)
  `ASSERT_IMP(a_tir_one, out_valid && out_total_reflection,
              out_reflectance == fdr_pkg::ONE_Q16)
  `ASSERT_IMP(a_div_lockstep, 1'b1, dvp_v == dvs_v && dvp_in_ready == dvs_in_ready)
  `ASSERT_IMP(a_div_side, dvp_v, dvp_forced == dvs_forced)
  `ASSERT_NXT(a_take_lands, in_valid && in_ready, s0_v_r)

endmodule

// File: tb/fresnel_dielectric_reflectance_test.sv
// ---------------------------------------------------------------------------
// fresnel_dielectric_reflectance_test
// Drives incident cosines and index pairs through the reflectance pipeline,
// predicts each result in integer arithmetic and compares it field by field
// under several idle and stall patterns on both channels.
// ---------------------------------------------------------------------------
module fresnel_dielectric_reflectance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [16:0] refl;
    logic        tir;
  } refl_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [15:0] in_cos_incident = '0;
  logic [15:0] in_eta_incident = '0;
  logic [15:0] in_eta_transmit = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] out_reflectance;
  logic        out_total_reflection;

  refl_t       expected_refl_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bit          failed = 1'b0;

  fresnel_dielectric_reflectance dut (.*);

  always #10 clk = ~clk;

  // Integer square root, floor
  function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
    logic [31:0] res;
    logic [31:0] bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] amp_ratio(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] diff;
    diff = (p >= q) ? p - q : q - p;
    return (diff << 16) / (p + q);
  endfunction

  function automatic refl_t predict_reflectance(input logic [15:0] raw,
                                                input logic [15:0] eta_i,
                                                input logic [15:0] eta_t);
    logic [31:0] ei, et, c, si, st, ct;
    logic [63:0] num, a, b, d, e, rp, rs, sum;
    refl_t r;
    ei = eta_i;
    et = eta_t;
    r.refl = 17'h1_0000;
    r.tir = 1'b1;
    // ray from the transmit side: swap indices, take the magnitude
    if (raw == 0 || raw[15]) begin
      ei = eta_t;
      et = eta_i;
      c = (raw == 0) ? 0 : (32'h1_0000 - raw);
    end else begin
      c = raw;
    end
    if (et == 0) return r;
    si = floor_sqrt(32'h4000_0000 - c * c);
    num = 64'(ei) * si;
    if (num >= 64'(et) * 32768) return r;
    st = 32'(num / et);
    ct = floor_sqrt(32'h4000_0000 - st * st);
    a = 64'(et) * c;
    b = 64'(ei) * ct;
    d = 64'(ei) * c;
    e = 64'(et) * ct;
    if (a + b == 0 || d + e == 0) return r;
    rp = amp_ratio(a, b);
    rs = amp_ratio(d, e);
    sum = rp * rp + rs * rs;
    r.refl = 17'((sum + 64'h1_0000) >> 17);
    r.tir = 1'b0;
    return r;
  endfunction

  // Hand over one item; drop valid only while the sender idles
  task automatic send_item(input logic [15:0] cosv, input logic [15:0] ei,
                           input logic [15:0] et);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cos_incident <= cosv;
    in_eta_incident <= ei;
    in_eta_transmit <= et;
    do @(posedge clk); while (!in_ready);
    expected_refl_q.push_back(predict_reflectance(cosv, ei, et));
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    refl_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_refl_q.size() == 0) begin
        $error("unexpected result reflectance=%0d", out_reflectance);
        failed = 1'b1;
      end else begin
        exp_r = expected_refl_q.pop_front();
        if (out_reflectance !== exp_r.refl) begin
          $error("reflectance expected %0d actual %0d", exp_r.refl, out_reflectance);
          failed = 1'b1;
        end
        if (out_total_reflection !== exp_r.tir) begin
          $error("total_reflection expected %0d actual %0d", exp_r.tir,
                 out_total_reflection);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no acceptance on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(16'h7fff, 16'd4096, 16'd6144);  // normal incidence
    send_item(16'h8000, 16'd4096, 16'd6144);  // exactly -1.0, swap
    send_item(16'h0000, 16'd6144, 16'd4096);  // zero cosine
    send_item(16'h0001, 16'd4096, 16'd6144);  // grazing
    send_item(16'hffff, 16'd4096, 16'd6144);
    send_item(16'h4000, 16'd6144, 16'd4096);  // total internal reflection
    send_item(16'h4000, 16'd4096, 16'd0);     // zero transmit index
    send_item(16'hc000, 16'd0, 16'd4096);     // zero after swap
    send_item(16'h4000, 16'd0, 16'd4096);     // zero incident index
    send_item(16'h4000, 16'd0, 16'd0);
    send_item(16'h7fff, 16'hffff, 16'hffff);
    send_item(16'h7fff, 16'hffff, 16'h0001);
    send_item(16'h7fff, 16'h0001, 16'hffff);
    send_item(16'h8000, 16'hffff, 16'h0001);
    send_item(16'h5a82, 16'd4096, 16'd4096);  // matched indices
    send_item(16'h2000, 16'd4096, 16'd5461);
    send_item(16'ha5a5, 16'h5a5a, 16'ha5a5);
  endtask

  task automatic test_random(input int unsigned n);
    logic [15:0] cosv, ei, et;
    repeat (n) begin
      cosv = 16'($urandom);
      case ($urandom_range(3))
        0: begin
          ei = 16'($urandom);
          et = 16'($urandom);
        end
        1: begin
          ei = 16'($urandom_range(7000, 3000));
          et = 16'($urandom_range(7000, 3000));
        end
        2: begin
          ei = 16'($urandom_range(6000, 4096));
          et = 16'($urandom_range(6000, 4096));
          cosv = 16'($urandom_range(32767, 1));
        end
        default: begin
          ei = 16'($urandom_range(3));
          et = 16'($urandom);
        end
      endcase
      send_item(cosv, ei, et);
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random(n);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    run_phase(0, 0, 600);
    run_phase(86, 0, 400);
    run_phase(0, 86, 400);
    run_phase(31, 31, 530);
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (expected_refl_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/fdr_pkg.sv
design/fdr_sqrt_pipe.sv
design/fdr_div_pipe.sv
design/fresnel_dielectric_reflectance.sv
tb/fresnel_dielectric_reflectance_test.sv
